/* rtl/edd_pkg.sv */
// ----------------------------------------------------------------------------
// edd_pkg
// Shared constants, types and register codes of the error diffusion ditherer.
// ----------------------------------------------------------------------------
package edd_pkg;

   localparam int MAX_WIDTH        = 2048;
   localparam int ERROR_BITS       = 11;
   localparam int GRAY_W           = 8;
   localparam int LINE_WIDTH_W     = 12;
   localparam int CSR_DATA_W       = 12;
   localparam int CSR_INDEX_W      = 1;
   localparam int LINE_WIDTH_RESET = 640;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int IDX_W      = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W      = (IDX_W > LINE_WIDTH_W) ? IDX_W : LINE_WIDTH_W;
   localparam int BANK_DEPTH = MAX_WIDTH / 2 + 1;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int SUM_W      = ERROR_BITS + 3;

   localparam int THRESHOLD       = 127;
   localparam int FULL_SCALE      = 255;
   localparam int QUARTER_SHIFT   = 2;
   localparam int SIXTEENTH_SHIFT = 4;

   typedef logic signed [ERROR_BITS-1:0] err_type;
   typedef logic [COL_W-1:0]             col_type;
   typedef logic [IDX_W-1:0]             idx_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH    = 1'b0,
      CSR_INVERT_OUTPUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              first_row;
      col_type           col;
      logic              row_last;
   } pix_type;

   typedef struct packed {
      logic    en;
      idx_type idx;
   } rd_req_type;

   typedef struct packed {
      logic    en;
      idx_type idx;
      err_type data;
   } wr_req_type;

endpackage

/* rtl/edd_if.sv */
// ----------------------------------------------------------------------------
// edd_req_if / edd_rsp_if
// Valid/ready channels for gray pixels in and dither dots out.
// ----------------------------------------------------------------------------
interface edd_req_if;
   import edd_pkg::*;

   logic              valid;
   logic              ready;
   logic [GRAY_W-1:0] gray_level;
   logic              frame_start;

   modport source (output valid, output gray_level, output frame_start, input ready);
   modport sink   (input valid, input gray_level, input frame_start, output ready);
endinterface

interface edd_rsp_if;
   logic valid;
   logic ready;
   logic dot;

   modport source (output valid, output dot, input ready);
   modport sink   (input valid, input dot, output ready);
endinterface

/* rtl/edd_ram.sv */
// ----------------------------------------------------------------------------
// edd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/edd_line_store.sv */
// ----------------------------------------------------------------------------
// edd_line_store
// Carried-error line store: even and odd banks, so that the row-end edge
// write and the column write land in one cycle, with same-cycle forwarding.
// ----------------------------------------------------------------------------
module edd_line_store (
   input  logic                clock,
   input  logic                reset,
   input  edd_pkg::rd_req_type rd_req,
   input  edd_pkg::wr_req_type wr_col,
   input  edd_pkg::wr_req_type wr_edge,
   output edd_pkg::err_type    rd_data
);
   import edd_pkg::*;

   logic          bank_wr_en   [2];
   logic [BANK_AW-1:0] bank_wr_addr [2];
   err_type       bank_wr_data [2];
   err_type       bank_rd_data [2];
   logic [BANK_AW-1:0] rd_addr;
   logic          hit_col;
   logic          hit_edge;
   logic          rd_par_ff,   rd_par_in;
   logic          byp_valid_ff, byp_valid_in;
   err_type       byp_data_ff, byp_data_in;

   assign rd_addr  = BANK_AW'(rd_req.idx >> 1);
   assign hit_col  = wr_col.en  && (wr_col.idx  == rd_req.idx);
   assign hit_edge = wr_edge.en && (wr_edge.idx == rd_req.idx);

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         if (wr_col.en && (wr_col.idx[0] == 1'(b))) begin
            bank_wr_en[b]   = 1'b1;
            bank_wr_addr[b] = BANK_AW'(wr_col.idx >> 1);
            bank_wr_data[b] = wr_col.data;
         end else begin
            bank_wr_en[b]   = wr_edge.en && (wr_edge.idx[0] == 1'(b));
            bank_wr_addr[b] = BANK_AW'(wr_edge.idx >> 1);
            bank_wr_data[b] = wr_edge.data;
         end
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_bank
      edd_ram #(
         .WIDTH (ERROR_BITS),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_wr_en[g]),
         .wr_addr (bank_wr_addr[g]),
         .wr_data (bank_wr_data[g]),
         .rd_en   (rd_req.en),
         .rd_addr (rd_addr),
         .rd_data (bank_rd_data[g])
      );
   end

   always_comb begin
      rd_par_in    = rd_par_ff;
      byp_valid_in = byp_valid_ff;
      byp_data_in  = byp_data_ff;
      if (rd_req.en) begin
         rd_par_in    = rd_req.idx[0];
         byp_valid_in = hit_col || hit_edge;
         byp_data_in  = hit_col ? wr_col.data : wr_edge.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= byp_valid_in;
      end
      rd_par_ff   <= rd_par_in;
      byp_data_ff <= byp_data_in;
   end

   assign rd_data = byp_valid_ff ? byp_data_ff : bank_rd_data[rd_par_ff];

endmodule

/* rtl/edd_diffuse.sv */
// ----------------------------------------------------------------------------
// edd_diffuse
// Threshold and error split for one pixel; holds the in-row carries and
// issues the line store writes.
// ----------------------------------------------------------------------------
module edd_diffuse (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  edd_pkg::pix_type    pix,
   input  edd_pkg::err_type    below_data,
   output logic                set,
   output edd_pkg::wr_req_type wr_col,
   output edd_pkg::wr_req_type wr_edge
);
   import edd_pkg::*;

   err_type q_ff,    q_in;
   err_type s_ff,    s_in;
   err_type diag_ff, diag_in;
   err_type down_ff, down_in;

   logic                    row_start;
   err_type                 q_c, s_c, diag_c, down_c, below;
   logic signed [SUM_W-1:0] e_wide, e_adj;
   err_type                 e, q_t, s_t;

   assign row_start = (pix.col == '0);
   assign q_c    = row_start ? '0 : q_ff;
   assign s_c    = row_start ? '0 : s_ff;
   assign diag_c = row_start ? '0 : diag_ff;
   assign down_c = row_start ? '0 : down_ff;
   assign below  = pix.first_row ? '0 : below_data;

   always_comb begin
      e_wide = $signed({{(SUM_W - GRAY_W){1'b0}}, pix.gray}) + SUM_W'(below)
               + SUM_W'(q_c) + SUM_W'(q_c) - SUM_W'(s_c);
      set    = (e_wide >= SUM_W'(THRESHOLD));
      e_adj  = set ? (e_wide - SUM_W'(FULL_SCALE)) : e_wide;
      e      = ERROR_BITS'(e_adj);
      q_t    = e + (e[ERROR_BITS-1] ? ERROR_BITS'((1 << QUARTER_SHIFT) - 1) : '0);
      s_t    = e + (e[ERROR_BITS-1] ? ERROR_BITS'((1 << SIXTEENTH_SHIFT) - 1) : '0);
      q_in    = q_t >>> QUARTER_SHIFT;
      s_in    = s_t >>> SIXTEENTH_SHIFT;
      down_in = diag_c + q_in + s_in;
      diag_in = s_in;

      wr_col.en    = advance;
      wr_col.idx   = IDX_W'(pix.col);
      wr_col.data  = down_c + q_in - s_in;
      wr_edge.en   = advance && pix.row_last;
      wr_edge.idx  = IDX_W'(pix.col) + IDX_W'(1);
      wr_edge.data = down_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff    <= '0;
         s_ff    <= '0;
         diag_ff <= '0;
         down_ff <= '0;
      end else if (advance) begin
         q_ff    <= q_in;
         s_ff    <= s_in;
         diag_ff <= diag_in;
         down_ff <= down_in;
      end
   end

endmodule

/* rtl/error_diffusion_dither_top.sv */
// ----------------------------------------------------------------------------
// error_diffusion_dither_top
// Floyd-Steinberg ditherer: 8-bit gray pixels in raster order to one-bit dots.
// ----------------------------------------------------------------------------
// Takes one pixel per clock when the result side is ready and returns one dot
// per pixel. A taken pixel first reads the carried error of the row above
// from the line store (registered read of two RAM banks of MAX_WIDTH/2+1
// entries each); the diffuse stage then forms the dot and the error split and
// writes the line store back. Set line_width and invert_output while the
// block is idle. Assert frame_start on the first pixel of each image: the
// first row then ignores the line store, which needs no clearing after reset.
// ----------------------------------------------------------------------------
module error_diffusion_dither_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [edd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [edd_pkg::CSR_DATA_W-1:0]     csr_write_data,
   edd_req_if.sink                            req_ch,
   edd_rsp_if.source                          rsp_ch
);
   import edd_pkg::*;

   logic [LINE_WIDTH_W-1:0] line_width_ff;
   logic                    invert_ff;

   col_type    column_ff,    column_in;
   logic       first_row_ff, first_row_in;
   logic       s1_valid_ff,  s1_valid_in;
   pix_type    s1_pix_ff,    s1_pix_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       dot_ff,       dot_in;

   logic       accept;
   logic       advance;
   logic [CMP_W-1:0] width_eff;
   col_type    col_cur;
   logic       first_cur;
   logic       last_cur;
   rd_req_type rd_req;
   wr_req_type wr_col;
   wr_req_type wr_edge;
   err_type    below_data;
   logic       set;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_W'(LINE_WIDTH_RESET);
         invert_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH:    line_width_ff <= csr_write_data[LINE_WIDTH_W-1:0];
            CSR_INVERT_OUTPUT: invert_ff     <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = CMP_W'(1);
      end else if (CMP_W'(line_width_ff) > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = CMP_W'(line_width_ff);
      end
   end

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign col_cur   = req_ch.frame_start ? '0 : column_ff;
   assign first_cur = req_ch.frame_start || first_row_ff;
   assign last_cur  = (CMP_W'(col_cur) + CMP_W'(1)) >= width_eff;

   always_comb begin
      column_in    = column_ff;
      first_row_in = first_row_ff;
      s1_pix_in    = s1_pix_ff;
      if (accept) begin
         column_in    = last_cur ? '0 : col_cur + COL_W'(1);
         first_row_in = last_cur ? 1'b0 : first_cur;
         s1_pix_in.gray      = req_ch.gray_level;
         s1_pix_in.first_row = first_cur;
         s1_pix_in.col       = col_cur;
         s1_pix_in.row_last  = last_cur;
      end
      rd_req.en  = accept;
      rd_req.idx = IDX_W'(col_cur) + IDX_W'(1);

      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      dot_in       = advance ? (set ^ invert_ff) : dot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_pix_ff <= s1_pix_in;
      dot_ff    <= dot_in;
   end

   edd_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_col  (wr_col),
      .wr_edge (wr_edge),
      .rd_data (below_data)
   );

   edd_diffuse u_diffuse (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pix        (s1_pix_ff),
      .below_data (below_data),
      .set        (set),
      .wr_col     (wr_col),
      .wr_edge    (wr_edge)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.dot   = dot_ff;

endmodule

/* bench/error_diffusion_dither_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// error_diffusion_dither_top_tb
// Self-checking bench for the Floyd-Steinberg error diffusion ditherer.
// ----------------------------------------------------------------------------
// Drives gray pixels through the request channel and checks every dot against
// a bit-accurate diffusion predictor kept in a small scoreboard class. A short
// directed run covers level extremes, the threshold, row ends, frame starts,
// both polarities and a width cut mid-row. Random phases then sweep the line
// width (zero, one, small, full and saturated), the polarity, and three flow
// patterns: mostly stalled result side, mostly idle source, and no idling.
// Frame starts are inserted wherever a row would read carried error that was
// never written since reset.
// ----------------------------------------------------------------------------
module error_diffusion_dither_top_tb;
   import edd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NUM_PHASES     = 12;

   class dither_scoreboard;
      logic [LINE_WIDTH_W-1:0] line_width;
      logic                    invert_output;
      err_type                 line_store[0:MAX_WIDTH];
      bit                      line_written[0:MAX_WIDTH];
      int unsigned             column;
      err_type                 quarter_err;
      err_type                 sixteenth_err;
      err_type                 diag_carry;
      err_type                 down_carry;
      bit                      first_row;
      logic                    expected_dots[$];
      int                      failures;

      function new();
         line_width    = LINE_WIDTH_W'(LINE_WIDTH_RESET);
         invert_output = 1'b0;
         foreach (line_store[i]) begin
            line_store[i]   = '0;
            line_written[i] = 1'b0;
         end
         column        = 0;
         quarter_err   = '0;
         sixteenth_err = '0;
         diag_carry    = '0;
         down_carry    = '0;
         first_row     = 1'b1;
         failures      = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_LINE_WIDTH:    line_width    = value[LINE_WIDTH_W-1:0];
            CSR_INVERT_OUTPUT: invert_output = value[0];
            default: ;
         endcase
      endfunction

      // True when the next pixel, sent without a frame start, would read an
      // entry of the line store that was never written.
      function bit store_unready();
         int unsigned c;
         c = (column >= MAX_WIDTH) ? 0 : column;
         return !first_row && !line_written[c + 1];
      endfunction

      function void note_pixel(logic [GRAY_W-1:0] gray, logic frame_start);
         int unsigned w;
         int          below;
         int          err;
         bit          dot_set;
         w = line_width;
         if (w == 0) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         if (frame_start) begin
            column    = 0;
            first_row = 1'b1;
         end
         if (column >= MAX_WIDTH) column = 0;
         if (column == 0) begin
            quarter_err   = '0;
            sixteenth_err = '0;
            diag_carry    = '0;
            down_carry    = '0;
         end
         below   = first_row ? 0 : int'(line_store[column + 1]);
         err     = int'(gray) + below + 2 * int'(quarter_err) - int'(sixteenth_err);
         dot_set = (err >= THRESHOLD);
         if (dot_set) err = err - FULL_SCALE;
         err           = int'(err_type'(err));
         quarter_err   = err_type'(err / 4);
         sixteenth_err = err_type'(err / 16);
         line_store[column]   = err_type'(int'(down_carry) + int'(quarter_err)
                                          - int'(sixteenth_err));
         line_written[column] = 1'b1;
         down_carry = err_type'(int'(diag_carry) + int'(quarter_err)
                                + int'(sixteenth_err));
         diag_carry = sixteenth_err;
         if (column + 1 >= w) begin
            line_store[column + 1]   = down_carry;
            line_written[column + 1] = 1'b1;
            first_row = 1'b0;
            column    = 0;
         end else begin
            column++;
         end
         expected_dots.push_back(dot_set ^ invert_output);
      endfunction

      function void check_dot(logic dot);
         logic want;
         if (expected_dots.size() == 0) begin
            $error("dot with no item pending: actual %0b", dot);
            failures++;
         end else begin
            want = expected_dots.pop_front();
            if (dot !== want) begin
               $error("dot mismatch: expected %0b, actual %0b", want, dot);
               failures++;
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   edd_req_if req_ch ();
   edd_rsp_if rsp_ch ();

   dither_scoreboard sb = new();

   int idle_pct;
   int stall_pct;
   int idle_cycles;

   error_diffusion_dither_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_pixel(req_ch.gray_level, req_ch.frame_start);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_dot(rsp_ch.dot);
   end

   always @(negedge clock)
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_pixel(logic [GRAY_W-1:0] gray, logic frame_start);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.gray_level  = gray;
      req_ch.frame_start = frame_start | sb.store_unready();
      req_ch.valid       = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_for_dots();
      req_ch.valid = 1'b0;
      while (sb.expected_dots.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int          count;
      int          drain_at;
      int          fs_pct;
      logic [11:0] width_value;
      logic [7:0]  gray;

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_LINE_WIDTH;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.gray_level  = '0;
      req_ch.frame_start = 1'b0;
      idle_pct           = 0;
      stall_pct          = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: rows of four, threshold edges, polarity, frame start
      write_register(CSR_LINE_WIDTH, 12'd4);
      write_register(CSR_INVERT_OUTPUT, 12'd0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd127, 1'b0);
      send_pixel(8'd126, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd1, 1'b0);
      wait_for_dots();
      write_register(CSR_INVERT_OUTPUT, 12'd1);
      send_pixel(8'd254, 1'b0);
      send_pixel(8'd127, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd60, 1'b0);
      send_pixel(8'd190, 1'b0);
      send_pixel(8'd127, 1'b0);
      send_pixel(8'd100, 1'b0);
      send_pixel(8'd170, 1'b0);
      wait_for_dots();
      // cut the width to the current column: row ends after next pixel
      write_register(CSR_LINE_WIDTH, 12'd2);
      send_pixel(8'd90, 1'b0);
      send_pixel(8'd140, 1'b0);
      send_pixel(8'd33, 1'b0);
      wait_for_dots();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 4) begin
            idle_pct  = 11;
            stall_pct = 76;
         end else if (p < 8) begin
            idle_pct  = 76;
            stall_pct = 11;
         end else begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         case (p)
            2:       width_value = 12'd0;
            5:       width_value = 12'd1;
            9:       width_value = 12'd2048;
            10:      width_value = 12'd4095;
            11:      width_value = 12'd2;
            default: width_value = 12'($urandom_range(3, 40));
         endcase
         count  = (p == 9) ? 600 : ((p == 10) ? 400 : 80);
         fs_pct = (p == 9 || p == 10) ? 0 : 3;
         write_register(CSR_LINE_WIDTH, width_value);
         write_register(CSR_INVERT_OUTPUT, 12'($urandom_range(1)));
         drain_at = $urandom_range(count - 1);
         for (int i = 0; i < count; i++) begin
            if (i == drain_at)
               wait_for_dots();
            case ($urandom_range(3))
               0:       gray = $urandom_range(1) ? 8'd255 : 8'd0;
               1:       gray = 8'($urandom_range(120, 135));
               default: gray = 8'($urandom_range(255));
            endcase
            send_pixel(gray, (p == 9 && i == 0) || ($urandom_range(99) < fs_pct));
         end
         wait_for_dots();
      end

      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.expected_dots.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* sim.f */
rtl/edd_pkg.sv
rtl/edd_if.sv
rtl/edd_ram.sv
rtl/edd_line_store.sv
rtl/edd_diffuse.sv
rtl/error_diffusion_dither_top.sv
bench/error_diffusion_dither_top_tb.sv
